// File: rtl/core/gpr_pkg.sv
// shared types, constants and the 5x7 font table of the glyph rasterizer
package gpr_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLOR_W = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned GLYPH_W = 7;
  localparam int unsigned FONT_COLS = 5;
  localparam int unsigned FONT_ENTRIES = 95;

  localparam logic [CODE_W-1:0] FIRST_CODE    = 8'h20;
  localparam logic [CODE_W-1:0] LAST_CODE     = 8'h7E;
  localparam logic [CODE_W-1:0] FALLBACK_CODE = 8'h3F;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // one entry per glyph, column 0 in the low byte, bit 0 of a byte is the top row
  localparam logic [39:0] FONT_ROM [0:FONT_ENTRIES-1] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
    40'h0041221C00, 40'h001C224100, 40'h14083E0814, 40'h08083E0808,
    40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
    40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
    40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
    40'h0041221408, 40'h1414141414, 40'h0814224100, 40'h0609510102,
    40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
    40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
    40'h404040407F, 40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E,
    40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
    40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040,
    40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
    40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3E5252520C,
    40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h004428107F,
    40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
    40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
    40'h00007F0000, 40'h0008364100, 40'h0810080810
  };

  // column byte of a glyph; columns past the font width read blank
  function automatic logic [7:0] glyph_column(input logic [GLYPH_W-1:0] glyph,
                                              input logic [2:0] col);
    logic [39:0] entry;
    entry = 40'h0;
    if (glyph < GLYPH_W'(FONT_ENTRIES)) begin
      entry = FONT_ROM[glyph];
    end
    if (col < 3'(FONT_COLS)) begin
      return entry[{col, 3'b000} +: 8];
    end
    return 8'h00;
  endfunction

  typedef struct packed {
    logic load;       // take a new request, restart the cell walk
    logic advance;    // move to the next glyph cell
    logic capture;    // keep the current cell as the held pixel
    logic push;       // move the held pixel into the output register
    logic push_last;  // mark the pushed pixel as the final write
  } gpr_cmd_t;

  typedef struct packed {
    logic cell_vis;   // current cell is set and inside the frame
    logic held_valid; // a pixel waits in the hold register
    logic out_free;   // output register can take a beat this cycle
    logic scan_end;   // current cell is the final one of the glyph
  } gpr_stat_t;

endpackage

// File: rtl/core/gpr_ctrl.sv
// controller state machine of the glyph rasterizer
module gpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  gpr_pkg::gpr_stat_t stat,
  output gpr_pkg::gpr_cmd_t  cmd
);
  import gpr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   stall;

  // a visible cell with a pixel already held needs the output register
  assign stall = stat.cell_vis && stat.held_valid && !stat.out_free;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          cmd.advance = 1'b1;
          cmd.capture = stat.cell_vis;
          cmd.push    = stat.cell_vis && stat.held_valid;
          if (stat.scan_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!stat.held_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/gpr_datapath.sv
// datapath: frame registers, request registers, cell walk, hold and output registers
module gpr_datapath #(
  parameter int unsigned GLYPH_COLUMNS = 5,
  parameter int unsigned GLYPH_ROWS    = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [gpr_pkg::COORD_W-1:0]  cfg_wdata,
  input  logic [gpr_pkg::CODE_W-1:0]   char_code,
  input  logic [gpr_pkg::COORD_W-1:0]  origin_x,
  input  logic [gpr_pkg::COORD_W-1:0]  origin_y,
  input  logic [gpr_pkg::COLOR_W-1:0]  ink_color,
  input  gpr_pkg::gpr_cmd_t            cmd,
  output gpr_pkg::gpr_stat_t           stat,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [gpr_pkg::ADDR_W-1:0]   pixel_address,
  output logic [gpr_pkg::COLOR_W-1:0]  pixel_color,
  output logic                         out_tlast
);
  import gpr_pkg::*;

  localparam int unsigned COL_W = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
  localparam int unsigned ROW_W = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

  logic [COORD_W-1:0] frame_width_r;
  logic [COORD_W-1:0] frame_height_r;

  logic [GLYPH_W-1:0] glyph_r;
  logic [COORD_W-1:0] ox_r;
  logic [COORD_W-1:0] oy_r;
  logic [COLOR_W-1:0] ink_r;
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;

  logic               held_valid_r;
  logic [ADDR_W-1:0]  held_prod_r;
  logic [COORD_W-1:0] held_px_r;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_addr_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  logic [CODE_W-1:0]  code_fixed;
  logic [7:0]         col_bits;
  logic               cell_bit;
  logic [COORD_W-1:0] px;
  logic [COORD_W-1:0] py;
  logic [ADDR_W-1:0]  row_prod;
  logic               col_end;
  logic               row_end;

  assign code_fixed = (char_code < FIRST_CODE || char_code > LAST_CODE) ?
                      FALLBACK_CODE : char_code;

  assign col_bits = glyph_column(glyph_r, 3'(col_r));
  assign cell_bit = col_bits[3'(row_r)];
  assign px       = ox_r + COORD_W'(col_r);
  assign py       = oy_r + COORD_W'(row_r);
  assign row_prod = {{(ADDR_W-COORD_W){1'b0}}, py} *
                    {{(ADDR_W-COORD_W){1'b0}}, frame_width_r};
  assign col_end  = (col_r == COL_W'(GLYPH_COLUMNS - 1));
  assign row_end  = (row_r == ROW_W'(GLYPH_ROWS - 1));

  assign stat.cell_vis   = cell_bit && (px < frame_width_r) && (py < frame_height_r);
  assign stat.held_valid = held_valid_r;
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.scan_end   = col_end && row_end;

  assign out_tvalid    = out_valid_r;
  assign pixel_address = out_addr_r;
  assign pixel_color   = out_color_r;
  assign out_tlast     = out_last_r;

  // configuration and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 16'd128;
      frame_height_r <= 16'd64;
      held_valid_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
          default: ;
        endcase
      end
      priority if (cmd.load) begin
        held_valid_r <= 1'b0;
      end else if (cmd.capture) begin
        held_valid_r <= 1'b1;
      end else if (cmd.push) begin
        held_valid_r <= 1'b0;
      end else begin
        held_valid_r <= held_valid_r;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // cell walk, column-major
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.load) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.advance && !(col_end && row_end)) begin
      if (row_end) begin
        row_r <= '0;
        col_r <= col_r + COL_W'(1);
      end else begin
        row_r <= row_r + ROW_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph_r <= GLYPH_W'(code_fixed - FIRST_CODE);
      ox_r    <= origin_x;
      oy_r    <= origin_y;
      ink_r   <= ink_color;
    end
    if (cmd.push) begin
      out_addr_r  <= held_prod_r + {{(ADDR_W-COORD_W){1'b0}}, held_px_r};
      out_color_r <= ink_r;
      out_last_r  <= cmd.push_last;
    end
    if (cmd.capture) begin
      held_prod_r <= row_prod;
      held_px_r   <= px;
    end
  end

endmodule

// File: rtl/core/glyph_pixel_rasterizer_core.sv
// Glyph pixel rasterizer: 5x7 bitmap font character generator, top level.
// Input stream: one beat is one character draw request (code, cell origin, colour).
// Output stream: one beat per frame buffer write (word address, colour), tlast on the
// final write of a character; a character whose pixels are all blank or clipped
// gives no beats at all.
// Codes outside 0x20..0x7E draw '?'. Coordinates wrap at 16 bits and pixels outside
// frame_width x frame_height are dropped. Address = row * frame_width + column.
// Configuration: cfg_index 0 = frame_width, 1 = frame_height; write only while idle.
// Flow: a request is loaded, then the walk takes one glyph cell a cycle through the single
// address multiplier while the output is not stalled, then the held pixel is flushed;
// a new request is taken only after the flush. The first write of a character leaves
// after the request is taken: it waits for the next visible pixel or the flush.
// A stalled receiver holds the output register; the walk stops only when a second
// visible pixel has to follow. in_tready is high whenever the walk is idle.
// Reset: rst_n synchronous, active low; frame size returns to 128 x 64 and any
// request in flight is discarded.
module glyph_pixel_rasterizer_core #(
  parameter int unsigned GLYPH_COLUMNS = 5,
  parameter int unsigned GLYPH_ROWS    = 7
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // char_code[7:0], origin_x[23:8], origin_y[39:24],
                                  // ink_color[55:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // pixel_address[31:0], pixel_color[47:32]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import gpr_pkg::*;

  gpr_cmd_t           cmd;
  gpr_stat_t          stat;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;

  assign out_tdata = {pixel_color, pixel_address};

  gpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gpr_datapath #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS),
    .GLYPH_ROWS    (GLYPH_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .char_code     (in_tdata[7:0]),
    .origin_x      (in_tdata[23:8]),
    .origin_y      (in_tdata[39:24]),
    .ink_color     (in_tdata[55:40]),
    .cmd           (cmd),
    .stat          (stat),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .pixel_address (pixel_address),
    .pixel_color   (pixel_color),
    .out_tlast     (out_tlast)
  );

endmodule
